// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  // Queue geometry
  localparam int DEPTH         = 16;
  localparam int PRIORITY_BITS = 8;

  // Port field widths
  localparam int CMD_W    = 2;
  localparam int IN_PRI_W = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Only the low PRIORITY_BITS of the 8-bit input priority are significant
  localparam int PRIO_W = (PRIORITY_BITS < IN_PRI_W) ? PRIORITY_BITS : IN_PRI_W;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PEEK    = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [VALUE_W-1:0] value;
  } spq_entry_t;

  // Shift controls broadcast to every cell
  typedef struct packed {
    logic enq;  // insert new entry, shift tail right
    logic deq;  // drop front, shift everything left
  } spq_ctrl_t;

endpackage

// ----- rtl/core/spq_in_if.sv -----
`timescale 1ns / 1ps

interface spq_in_if import spq_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [IN_PRI_W-1:0]        in_priority;
  logic signed [VALUE_W-1:0]  in_value;

  modport source (output valid, command, in_priority, in_value, input ready);
  modport sink   (input valid, command, in_priority, in_value, output ready);
endinterface

// ----- rtl/core/spq_out_if.sv -----
`timescale 1ns / 1ps

interface spq_out_if import spq_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  out_value;
  logic [STATUS_W-1:0]        status;
  logic                       is_empty;
  logic [OCC_W-1:0]           occupancy;

  modport source (output valid, out_value, status, is_empty, occupancy, input ready);
  modport sink   (input valid, out_value, status, is_empty, occupancy, output ready);
endinterface

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic               clk,
  input  spq_ctrl_t          ctrl,
  input  logic               occ,
  input  logic [PRIO_W-1:0]  new_prio,
  input  logic [VALUE_W-1:0] new_value,
  input  spq_entry_t         left_entry,
  input  logic               left_ins,
  input  spq_entry_t         right_entry,
  output spq_entry_t         entry,
  output logic               ins
);

  spq_entry_t entry_next;

  // New entry lands at or before this cell: slot free, or strictly worse priority here
  assign ins = !occ || (entry.prio > new_prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.enq) begin
      if (left_ins) begin
        entry_next = left_entry;
      end else if (ins) begin
        entry_next.prio  = new_prio;
        entry_next.value = new_value;
      end
    end else if (ctrl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- rtl/core/stable_priority_queue.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Transfer when            Payload
// in_ch     in   in_ch.valid & ready      command, in_priority, in_value
// out_ch    out  out_ch.valid & ready     out_value, status, is_empty, occupancy
//
// One command per cycle while in_ch is ready: every cell compares its
// priority with the incoming one in parallel and shifts with its neighbor in
// the same cycle. The result register is the only stage; out_ch goes valid in
// the cycle after the in_ch transfer. in_ch is ready whenever the result
// register is empty or is being drained in the same cycle.
// Synchronous reset empties the queue and the result register; cell contents
// are left as they are and are never read before written.

module stable_priority_queue import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  spq_in_if.sink      in_ch,
  spq_out_if.source   out_ch
);

  // ---------------------------------------------------------------------
  // Occupancy and command decode
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               in_xfer;
  logic               full;
  logic               empty;
  logic [PRIO_W-1:0]  new_prio;
  spq_ctrl_t          ctrl;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign full        = (count == CNT_W'(DEPTH));
  assign empty       = (count == '0);
  assign new_prio    = in_ch.in_priority[PRIO_W-1:0];

  // ---------------------------------------------------------------------
  // Cell chain: cell 0 is the front of the queue
  // ---------------------------------------------------------------------
  spq_entry_t cell_entry [DEPTH];
  logic       cell_ins   [DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      spq_entry_t left_e;
      spq_entry_t right_e;
      logic       left_i;
      logic       occ;

      assign occ = (CNT_W'(gi) < count);

      if (gi == 0) begin : g_head
        assign left_e = '0;
        assign left_i = 1'b0;
      end else begin : g_mid
        assign left_e = cell_entry[gi-1];
        assign left_i = cell_ins[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_e = '0;
      end else begin : g_body
        assign right_e = cell_entry[gi+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occ         (occ),
        .new_prio    (new_prio),
        .new_value   (in_ch.in_value),
        .left_entry  (left_e),
        .left_ins    (left_i),
        .right_entry (right_e),
        .entry       (cell_entry[gi]),
        .ins         (cell_ins[gi])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------
  // Per-command result and shift controls
  // ---------------------------------------------------------------------
  status_t            res_status;
  logic [VALUE_W-1:0] res_value;

  always_comb begin
    ctrl       = '0;
    count_next = count;
    res_status = ST_OK;
    res_value  = '0;
    if (in_xfer) begin
      unique case (in_ch.command)
        CMD_ENQUEUE: begin
          if (full) begin
            res_status = ST_OVERFLOW;  // dropped
          end else begin
            ctrl.enq   = 1'b1;
            count_next = count + 1'b1;
          end
        end
        CMD_DEQUEUE: begin
          if (empty) begin
            res_status = ST_UNDERFLOW;
          end else begin
            res_value  = cell_entry[0].value;
            ctrl.deq   = 1'b1;
            count_next = count - 1'b1;
          end
        end
        CMD_PEEK: begin
          if (empty) begin
            res_status = ST_UNDERFLOW;
          end else begin
            res_value = cell_entry[0].value;
          end
        end
        default: begin
          // unused command code: no operation
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_ch.valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_ch.out_value <= res_value;
      out_ch.status    <= res_status;
      out_ch.is_empty  <= (count_next == '0);
      out_ch.occupancy <= OCC_W'(count_next);
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond queue depth");

  a_deq_shrinks: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_ch.command == CMD_DEQUEUE && !empty) |=> count == $past(count) - 1'b1)
    else $error("dequeue did not remove one entry");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_ch.command == CMD_ENQUEUE && full)
      |=> out_ch.valid && out_ch.status == ST_OVERFLOW && count == CNT_W'(DEPTH))
    else $error("enqueue on full queue not reported as overflow");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

endmodule

// ----- dv/spq_order_checker.sv -----
`timescale 1ns / 1ps

module spq_order_checker import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  spq_in_if           in_ch,
  spq_out_if          out_ch,
  output int unsigned errors,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    status_t             status;
    logic                is_empty;
    logic [OCC_W-1:0]    occupancy;
  } queue_reply_t;

  // Shadow of the sorted cells; slot 0 is the front.
  logic [PRIO_W-1:0]  rank [DEPTH];
  logic [VALUE_W-1:0] payload [DEPTH];
  int unsigned        held;

  queue_reply_t awaited_replies [$];
  queue_reply_t want;

  function automatic queue_reply_t serve_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [PRIO_W-1:0] prio,
                                                 input logic [VALUE_W-1:0] val);
    queue_reply_t r;
    int unsigned  pos;
    r.value  = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ENQUEUE: begin
        if (held >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          // new entry lands behind every equal or better priority
          pos = 0;
          while (pos < held && rank[pos] <= prio) pos++;
          for (int k = held; k > pos; k--) begin
            rank[k]    = rank[k-1];
            payload[k] = payload[k-1];
          end
          rank[pos]    = prio;
          payload[pos] = val;
          held++;
        end
      end
      CMD_DEQUEUE, CMD_PEEK: begin
        if (held == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.value = payload[0];
          if (cmd == CMD_DEQUEUE) begin
            for (int k = 0; k + 1 < held; k++) begin
              rank[k]    = rank[k+1];
              payload[k] = payload[k+1];
            end
            held--;
          end
        end
      end
      default: ;
    endcase
    r.is_empty  = (held == 0);
    r.occupancy = OCC_W'(held);
    return r;
  endfunction

  task automatic compare_field(input string label, input logic [VALUE_W-1:0] exp_v,
                               input logic [VALUE_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, label, exp_v, got_v);
      errors++;
    end
  endtask

  // Output side first: a result leaving in the same cycle belongs to an older command.
  always @(posedge clk) begin
    if (rst) begin
      held = 0;
      awaited_replies.delete();
      outstanding <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t unexpected result: expected none, actual value %0h status %0d",
                   $time, out_ch.out_value, out_ch.status);
          errors++;
        end else begin
          want = awaited_replies.pop_front();
          compare_field("out_value", want.value, out_ch.out_value);
          compare_field("status", VALUE_W'(want.status), VALUE_W'(out_ch.status));
          compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(out_ch.is_empty));
          compare_field("occupancy", VALUE_W'(want.occupancy), VALUE_W'(out_ch.occupancy));
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_replies.push_back(serve_command(in_ch.command,
                                                in_ch.in_priority[PRIO_W-1:0],
                                                in_ch.in_value));
      outstanding <= awaited_replies.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  // Command code 3 is not decoded by the block; it must act as a no-op.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // Random part: phases of fixed length, each with its own enqueue bias
  // so the queue swings between full (overflow) and empty (underflow).
  localparam int PHASES     = 17;
  localparam int PHASE_LEN  = 100;
  localparam int LONG_HOLD  = 200;

  logic clk;
  logic rst;

  spq_in_if  in_ch();
  spq_out_if out_ch();

  int unsigned errors;
  int unsigned outstanding;

  // Per-phase flags: when set, that side adds no random idle gaps between transfers.
  bit sender_quiet;
  bit receiver_quiet;

  stable_priority_queue i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  spq_order_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one command: idle for a random gap unless sender_quiet, then hold
  // valid until the transfer. valid is only lowered when a gap follows, so it
  // never gets two updates in one step.
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [IN_PRI_W-1:0] prio,
                       input logic [VALUE_W-1:0] val);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.in_priority <= prio;
    in_ch.in_value    <= val;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // Result side. Around two points in the run it holds ready low for a long
  // stretch while the sender keeps pushing, so the result register fills and
  // in_ch backs up.
  initial begin
    int unsigned taken;
    int          stall;
    taken        = 0;
    out_ch.ready = 1'b0;
    forever begin
      if (taken == 300 || taken == 1100)
        stall = LONG_HOLD;
      else
        stall = receiver_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      taken++;
    end
  end

  initial begin
    int                 enq_pct;
    int                 roll;
    bit                 narrow;
    logic [CMD_W-1:0]   cmd;
    logic [IN_PRI_W-1:0] prio;

    rst               = 1'b1;
    sender_quiet      = 1'b0;
    receiver_quiet    = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_ENQUEUE;
    in_ch.in_priority = '0;
    in_ch.in_value    = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queue cases, field extremes, ties, no-op.
    offer(CMD_DEQUEUE, 8'h00, 32'h0000_0000);   // underflow
    offer(CMD_PEEK,    8'hFF, 32'hFFFF_FFFF);   // underflow
    offer(CMD_NOP,     8'hA5, 32'h5A5A_5A5A);   // no-op on empty
    offer(CMD_ENQUEUE, 8'hFF, 32'h7FFF_FFFF);
    offer(CMD_ENQUEUE, 8'h00, 32'h8000_0000);   // jumps to the front
    offer(CMD_PEEK,    8'h00, 32'h0000_0000);
    offer(CMD_ENQUEUE, 8'h00, 32'hFFFF_FFFF);   // tie: behind the older 0
    offer(CMD_ENQUEUE, 8'h80, 32'h0000_0000);
    offer(CMD_ENQUEUE, 8'hFF, 32'h0000_0001);   // tie at the tail
    offer(CMD_NOP,     8'h5A, 32'hA5A5_A5A5);   // no-op with entries held
    repeat (5) offer(CMD_DEQUEUE, 8'h00, 32'h0000_0000);
    offer(CMD_DEQUEUE, 8'hFF, 32'h0000_0000);   // drained: underflow again

    // Random phases; bias cycles high / balanced / low so full and empty
    // both recur. Narrow priorities stress ordering among equal priorities.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0:       enq_pct = 80;
        1:       enq_pct = 50;
        default: enq_pct = 15;
      endcase
      narrow         = $urandom_range(0, 1);
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_LEN; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          cmd = CMD_NOP;
        else if (roll < 3 + enq_pct)
          cmd = CMD_ENQUEUE;
        else if ($urandom_range(0, 3) == 0)
          cmd = CMD_PEEK;
        else
          cmd = CMD_DEQUEUE;
        if (narrow)
          prio = IN_PRI_W'($urandom_range(0, 3));
        else
          prio = IN_PRI_W'($urandom_range(0, 255));
        offer(cmd, prio, $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    // Let the last transfer reach the count, then drain, then keep clocking
    // to catch stray results.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_in_if.sv
rtl/core/spq_out_if.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue.sv
dv/spq_order_checker.sv
dv/testbench.sv
